@@ rtl/tun_pkg.sv @@
package tun_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // normalized magnitude width and derived widths
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int FRAC_W = 14;
    localparam int Q_W    = FRAC_W + 1;
    localparam int NUM_W  = MAG_W + Q_W;
    localparam int OUT_W  = 16;

    // word handed along the square root chain
    typedef struct packed {
        logic [SUM_W-1:0]            x;
        logic [REM_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
        logic [2:0][MAG_W-1:0]       m;
        logic [2:0]                  neg;
        logic                        deg;
    } sq_word_t;

    // word handed along the divider chain
    typedef struct packed {
        logic [ROOT_W-1:0]           len;
        logic [2:0][NUM_W-1:0]       rem;
        logic [2:0][Q_W-1:0]         q;
        logic [2:0]                  neg;
        logic                        deg;
    } dv_word_t;

endpackage

@@ rtl/triangle_unit_normal_top.sv @@
// Triangle unit normal, fully pipelined.
// Input: pulse start with the nine vertex coordinates (signed Q8.8, COORD_BITS
// wide) of A, B, C. A word is taken at any clock edge with start high; busy
// is always low, so a new triangle may enter every cycle.
// Output: done is high for exactly one cycle with norm_x/y/z (signed Q1.14)
// and degenerate. The receiver cannot stall; results must be taken as shown.
// The path from accept to done runs through 9 front stages
// (edges, products, cross terms, sign and magnitude, combined bit pattern,
// bit length, normalize, squares, sum), one cell per root bit in the
// 31-cell square root chain, one numerator stage, one cell per quotient
// bit in the 15-cell divider chain, and the output register.
// Throughput is one triangle per cycle.
// A zero cross product gives degenerate high and zero components.
// Reset clears all valid flags; words in flight are dropped and no done
// follows for them.
module triangle_unit_normal_top
#(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    output logic                         done,
    output logic signed [15:0]           norm_x,
    output logic signed [15:0]           norm_y,
    output logic signed [15:0]           norm_z,
    output logic                         degenerate
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int LW  = $clog2(NW + 1);
    localparam int SHW = NW + tun_pkg::MAG_W;
    localparam int LAT = 9 + tun_pkg::ROOT_W + 1 + tun_pkg::Q_W + 1;

    // front pipeline valid flags, stage 1 to 9
    logic [8:0] fv_reg;

    logic signed [DW-1:0]        ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PW-1:0]        p_reg [6];
    logic signed [NW-1:0]        n_reg [3];
    logic [NW-1:0]               mag4_reg [3];
    logic [NW-1:0]               mag5_reg [3];
    logic [NW-1:0]               mag6_reg [3];
    logic [NW-1:0]               orv_reg;
    logic [LW-1:0]               lmax_reg;
    logic [LW-1:0]               lmax_next;
    logic [2:0]                  neg4_reg, neg5_reg, neg6_reg, neg7_reg, neg8_reg, neg9_reg;
    logic                        deg6_reg, deg7_reg, deg8_reg, deg9_reg;
    logic [tun_pkg::MAG_W-1:0]   m7_reg [3];
    logic [tun_pkg::MAG_W-1:0]   m8_reg [3];
    logic [tun_pkg::MAG_W-1:0]   m9_reg [3];
    logic [tun_pkg::SQ_W-1:0]    sq_reg [3];
    logic [tun_pkg::SUM_W-1:0]   sum_reg;
    logic [SHW-1:0]              shw [3];

    // front valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else
            fv_reg <= {fv_reg[7:0], start};
    end

    // leading one of the combined magnitudes
    always_comb
    begin
        lmax_next = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (orv_reg[i])
                lmax_next = LW'(i + 1);
        end
    end

    // common normalizing shift: top set bit lands at the top of the word
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            shw[i] = {mag6_reg[i], tun_pkg::MAG_W'(0)} >> lmax_reg;
    end

    // front data stages
    always_ff @(posedge clk)
    begin
        // edge vectors
        ux_reg <= DW'(b_x) - DW'(a_x);
        uy_reg <= DW'(b_y) - DW'(a_y);
        uz_reg <= DW'(b_z) - DW'(a_z);
        vx_reg <= DW'(c_x) - DW'(a_x);
        vy_reg <= DW'(c_y) - DW'(a_y);
        vz_reg <= DW'(c_z) - DW'(a_z);
        // products
        p_reg[0] <= uy_reg * vz_reg;
        p_reg[1] <= uz_reg * vy_reg;
        p_reg[2] <= uz_reg * vx_reg;
        p_reg[3] <= ux_reg * vz_reg;
        p_reg[4] <= ux_reg * vy_reg;
        p_reg[5] <= uy_reg * vx_reg;
        // cross terms
        n_reg[0] <= NW'(p_reg[0]) - NW'(p_reg[1]);
        n_reg[1] <= NW'(p_reg[2]) - NW'(p_reg[3]);
        n_reg[2] <= NW'(p_reg[4]) - NW'(p_reg[5]);
        // sign and magnitude
        for (int i = 0; i < 3; i++)
        begin
            neg4_reg[i] <= n_reg[i][NW-1];
            mag4_reg[i] <= n_reg[i][NW-1] ? NW'(-n_reg[i]) : NW'(n_reg[i]);
        end
        // combined bit pattern
        orv_reg  <= mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        mag5_reg <= mag4_reg;
        neg5_reg <= neg4_reg;
        // bit length
        lmax_reg <= lmax_next;
        deg6_reg <= (orv_reg == '0);
        mag6_reg <= mag5_reg;
        neg6_reg <= neg5_reg;
        // normalize
        for (int i = 0; i < 3; i++)
            m7_reg[i] <= shw[i][tun_pkg::MAG_W-1:0];
        deg7_reg <= deg6_reg;
        neg7_reg <= neg6_reg;
        // squares
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= m7_reg[i] * m7_reg[i];
        m8_reg   <= m7_reg;
        deg8_reg <= deg7_reg;
        neg8_reg <= neg7_reg;
        // sum of squares
        sum_reg  <= tun_pkg::SUM_W'(sq_reg[0]) + tun_pkg::SUM_W'(sq_reg[1])
                  + tun_pkg::SUM_W'(sq_reg[2]);
        m9_reg   <= m8_reg;
        deg9_reg <= deg8_reg;
        neg9_reg <= neg8_reg;
    end

    // square root chain
    tun_pkg::sq_word_t sq_first;
    tun_pkg::sq_word_t sq_w [tun_pkg::ROOT_W+1];
    logic              sq_v [tun_pkg::ROOT_W+1];

    always_comb
    begin
        sq_first      = '0;
        sq_first.x    = sum_reg;
        for (int i = 0; i < 3; i++)
            sq_first.m[i] = m9_reg[i];
        sq_first.neg  = neg9_reg;
        sq_first.deg  = deg9_reg;
    end

    assign sq_v[0] = fv_reg[8];
    assign sq_w[0] = sq_first;

    for (genvar g = 0; g < tun_pkg::ROOT_W; g++)
    begin : g_sqrt
        tun_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[g]),
            .in_word   (sq_w[g]),
            .out_valid (sq_v[g+1]),
            .out_word  (sq_w[g+1])
        );
    end

    // numerator with half-divisor rounding
    tun_pkg::sq_word_t sq_last;
    tun_pkg::dv_word_t dv_w [tun_pkg::Q_W+1];
    logic              dv_v [tun_pkg::Q_W+1];
    logic              nv_reg;
    tun_pkg::dv_word_t nw_reg;

    assign sq_last = sq_w[tun_pkg::ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else
            nv_reg <= sq_v[tun_pkg::ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        nw_reg.len <= sq_last.root;
        for (int i = 0; i < 3; i++)
        begin
            nw_reg.rem[i] <= {sq_last.m[i], tun_pkg::FRAC_W'(0)}
                           + tun_pkg::NUM_W'(sq_last.root >> 1);
            nw_reg.q[i]   <= '0;
        end
        nw_reg.neg <= sq_last.neg;
        nw_reg.deg <= sq_last.deg;
    end

    assign dv_v[0] = nv_reg;
    assign dv_w[0] = nw_reg;

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < tun_pkg::Q_W; g++)
    begin : g_div
        tun_div_cell #(.K(tun_pkg::Q_W - 1 - g)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[g]),
            .in_word   (dv_w[g]),
            .out_valid (dv_v[g+1]),
            .out_word  (dv_w[g+1])
        );
    end

    // output register
    tun_pkg::dv_word_t    dv_last;
    logic                 done_reg;
    logic signed [15:0]   nrm_reg [3];
    logic                 deg_reg;

    assign dv_last = dv_w[tun_pkg::Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_v[tun_pkg::Q_W];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_last.deg)
                nrm_reg[i] <= '0;
            else if (dv_last.neg[i])
                nrm_reg[i] <= -$signed(tun_pkg::OUT_W'(dv_last.q[i]));
            else
                nrm_reg[i] <= $signed(tun_pkg::OUT_W'(dv_last.q[i]));
        end
        deg_reg <= dv_last.deg;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign norm_x     = nrm_reg[0];
    assign norm_y     = nrm_reg[1];
    assign norm_z     = nrm_reg[2];
    assign degenerate = deg_reg;

`ifndef SYNTHESIS
    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word did not complete after pipeline latency");

    // no word comes out that was not accepted
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(fv_reg[8], LAT - 9)) |-> 1'b0)
        else $error("result without matching accepted word");

    // degenerate results carry zero components
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (norm_x == 0 && norm_y == 0 && norm_z == 0))
        else $error("degenerate result with nonzero component");

    // unit normal components stay within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !degenerate) |->
        (norm_x <= 16384 && norm_x >= -16384 && norm_y <= 16384 &&
         norm_y >= -16384 && norm_z <= 16384 && norm_z >= -16384))
        else $error("normal component out of range");
`endif

endmodule

@@ rtl/tun_sqrt_cell.sv @@
module tun_sqrt_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tun_pkg::sq_word_t  in_word,
    output logic               out_valid,
    output tun_pkg::sq_word_t  out_word
);

    localparam int CUR_W = tun_pkg::REM_W + 2;

    logic [CUR_W-1:0]  cur;
    logic [CUR_W-1:0]  trial;
    tun_pkg::sq_word_t word_next;
    tun_pkg::sq_word_t word_reg;
    logic              valid_reg;

    // one root bit per cell: bring down two radicand bits and try the subtraction
    always_comb
    begin
        word_next = in_word;
        cur   = {in_word.rem, in_word.x[tun_pkg::SUM_W-1 -: 2]};
        trial = CUR_W'({in_word.root, 2'b01});
        word_next.x = {in_word.x[tun_pkg::SUM_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            word_next.rem  = tun_pkg::REM_W'(cur - trial);
            word_next.root = {in_word.root[tun_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            word_next.rem  = cur[tun_pkg::REM_W-1:0];
            word_next.root = {in_word.root[tun_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

@@ rtl/tun_div_cell.sv @@
module tun_div_cell
#(
    parameter int K = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tun_pkg::dv_word_t  in_word,
    output logic               out_valid,
    output tun_pkg::dv_word_t  out_word
);

    logic [tun_pkg::NUM_W-1:0] dshift;
    tun_pkg::dv_word_t         word_next;
    tun_pkg::dv_word_t         word_reg;
    logic                      valid_reg;

    // one quotient bit per cell for all three components
    always_comb
    begin
        word_next = in_word;
        dshift = tun_pkg::NUM_W'(in_word.len) << K;
        for (int i = 0; i < 3; i++)
        begin
            if (in_word.rem[i] >= dshift)
            begin
                word_next.rem[i] = in_word.rem[i] - dshift;
                word_next.q[i]   = {in_word.q[i][tun_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                word_next.q[i]   = {in_word.q[i][tun_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
